// File: hdl/svga_pkg.sv
package svga_pkg;

  // One complex amplitude: real part in the low half, imaginary part in the high half.
  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } amp_t;

  // The 2x2 complex gate [[a b][c d]], all parts Q1.15.
  typedef struct packed {
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    logic signed [15:0] c_re;
    logic signed [15:0] c_im;
    logic signed [15:0] d_re;
    logic signed [15:0] d_im;
  } gate_t;

  typedef logic [1:0] op_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_GATE  = 2'd2;

  localparam int CFG_REGS = 8;

  localparam logic [2:0] CFG_A_RE = 3'd0;
  localparam logic [2:0] CFG_A_IM = 3'd1;
  localparam logic [2:0] CFG_B_RE = 3'd2;
  localparam logic [2:0] CFG_B_IM = 3'd3;
  localparam logic [2:0] CFG_C_RE = 3'd4;
  localparam logic [2:0] CFG_C_IM = 3'd5;
  localparam logic [2:0] CFG_D_RE = 3'd6;
  localparam logic [2:0] CFG_D_IM = 3'd7;

  localparam logic [15:0] CFG_RESET [CFG_REGS] = '{
    16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h7FFF, 16'h0000
  };

  // Basis state zero holds 1.0, saturated to the largest Q1.15 value.
  localparam amp_t AMP_ONE = '{im: 16'sh0000, re: 16'sh7FFF};

endpackage

// File: hdl/svga_ram.sv
module svga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/svga_cmac.sv
module svga_cmac #(
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_en,
  input  logic                in_sel,
  input  logic [AW-1:0]       in_addr,
  input  svga_pkg::amp_t      in_z,
  input  svga_pkg::amp_t      in_o,
  input  svga_pkg::gate_t     coef,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output svga_pkg::amp_t      wr_data
);

  // Row select: row 0 (a, b) gives the new zero-side entry, row 1 (c, d) the one-side entry.
  logic signed [15:0] m_re, m_im, n_re, n_im;
  logic signed [31:0] prod_r [8];
  logic               en_r;
  logic [AW-1:0]      addr_r;
  logic signed [33:0] sum_re, sum_im;

  function automatic logic signed [15:0] round_sat(input logic signed [33:0] s);
    logic signed [34:0] t;
    logic signed [19:0] q;
    t = 35'(s) + 35'sd16384;
    q = 20'(t >>> 15);
    if (q > 20'sd32767) begin
      round_sat = 16'sh7FFF;
    end else if (q < -20'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = q[15:0];
    end
  endfunction

  always_comb begin
    if (in_sel) begin
      m_re = coef.c_re;
      m_im = coef.c_im;
      n_re = coef.d_re;
      n_im = coef.d_im;
    end else begin
      m_re = coef.a_re;
      m_im = coef.a_im;
      n_re = coef.b_re;
      n_im = coef.b_im;
    end
  end

  always_ff @(posedge clk) begin
    prod_r[0] <= m_re * in_z.re;
    prod_r[1] <= m_im * in_z.im;
    prod_r[2] <= n_re * in_o.re;
    prod_r[3] <= n_im * in_o.im;
    prod_r[4] <= m_re * in_z.im;
    prod_r[5] <= m_im * in_z.re;
    prod_r[6] <= n_re * in_o.im;
    prod_r[7] <= n_im * in_o.re;
    addr_r    <= in_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= in_en;
    end
  end

  assign sum_re = 34'(prod_r[0]) - 34'(prod_r[1]) + 34'(prod_r[2]) - 34'(prod_r[3]);
  assign sum_im = 34'(prod_r[4]) + 34'(prod_r[5]) + 34'(prod_r[6]) + 34'(prod_r[7]);

  assign wr_en      = en_r;
  assign wr_addr    = addr_r;
  assign wr_data.re = round_sat(sum_re);
  assign wr_data.im = round_sat(sum_im);

endmodule

// File: hdl/svga_prob.sv
module svga_prob (
  input  logic           clk,
  input  logic           load,
  input  svga_pkg::amp_t amp,
  output svga_pkg::amp_t amp_out,
  output logic [15:0]    probability
);

  logic [31:0]    sq_re_r, sq_im_r;
  svga_pkg::amp_t amp_r;
  logic [32:0]    mag;
  logic [32:0]    rnd;
  logic [17:0]    q;

  always_ff @(posedge clk) begin
    if (load) begin
      sq_re_r <= 32'(amp.re * amp.re);
      sq_im_r <= 32'(amp.im * amp.im);
      amp_r   <= amp;
    end
  end

  // Both squares are non-negative and at most 2^30, so the sum fits in 33 bits.
  assign mag         = 33'(sq_re_r) + 33'(sq_im_r);
  assign rnd         = mag + 33'd16384;
  assign q           = rnd[32:15];
  assign probability = (|q[17:16]) ? 16'hFFFF : q[15:0];
  assign amp_out     = amp_r;

endmodule

// File: hdl/state_vector_gate_apply.sv
// Channel     Direction  Handshake           Content
// in_         slave      tvalid/tready       one request: tuser = operation, tdata = operands
// out_        master     tvalid/tready       one read result: amplitude and probability
// cfg_        APB slave  psel/penable/pready the eight gate coefficient registers
//
// After reset the store is cleared by a sweep over all 2^QUBITS entries (1024 by default),
// during which no request is taken; configuration writes are accepted throughout.
// A write request is stored in S_WR; a read request goes through S_RD, S_RD1 and S_RD2 to
// its result register. A gate request reads every entry once through the single-port-pair
// memory, writes back those entries that meet the control mask, then drains the multiply
// pipeline. A read result waits in the output register; a further read stalls in its last
// step until that register has been taken.
module state_vector_gate_apply #(
  parameter int QUBITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // operation
  input  logic [55:0] in_tdata,   // address, write_re, write_im, target_index, control_mask
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_re, read_im, probability
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW    = QUBITS;
  localparam int DEPTH = 1 << QUBITS;
  // Width wide enough for both an entry index and the ten-bit address and control mask.
  localparam int MW    = (QUBITS > 10) ? QUBITS : 10;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_RD2   = 3'd5;
  localparam logic [2:0] S_GATE  = 3'd6;
  localparam logic [2:0] S_DRAIN = 3'd7;

  // Request fields as they arrive.
  logic [9:0]  in_address;
  logic [15:0] in_write_re, in_write_im;
  logic [3:0]  in_target_index;
  logic [9:0]  in_control_mask;
  logic        in_accept;
  logic [MW-1:0] in_addr_ext;

  assign in_address      = in_tdata[9:0];
  assign in_write_re     = in_tdata[25:10];
  assign in_write_im     = in_tdata[41:26];
  assign in_target_index = in_tdata[45:42];
  assign in_control_mask = in_tdata[55:46];
  assign in_accept       = in_tvalid && in_tready;
  assign in_addr_ext     = MW'(in_address);

  // Configuration registers. Writes land at the access phase; pready is tied high.
  logic [15:0]     cfg_r [svga_pkg::CFG_REGS];
  logic            cfg_wr;
  svga_pkg::gate_t coef;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {16'h0000, cfg_r[cfg_paddr[4:2]]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < svga_pkg::CFG_REGS; i++) begin
        cfg_r[i] <= svga_pkg::CFG_RESET[i];
      end
    end else if (cfg_wr) begin
      cfg_r[cfg_paddr[4:2]] <= cfg_pwdata[15:0];
    end
  end

  assign coef.a_re = cfg_r[svga_pkg::CFG_A_RE];
  assign coef.a_im = cfg_r[svga_pkg::CFG_A_IM];
  assign coef.b_re = cfg_r[svga_pkg::CFG_B_RE];
  assign coef.b_im = cfg_r[svga_pkg::CFG_B_IM];
  assign coef.c_re = cfg_r[svga_pkg::CFG_C_RE];
  assign coef.c_im = cfg_r[svga_pkg::CFG_C_IM];
  assign coef.d_re = cfg_r[svga_pkg::CFG_D_RE];
  assign coef.d_im = cfg_r[svga_pkg::CFG_D_IM];

  // Sequencer state and the request held while it is worked on.
  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0]   item_addr_r;
  svga_pkg::amp_t  item_amp_r;
  logic [3:0]      item_tgt_r;
  logic [9:0]      item_mask_r;

  // Memory ports.
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  svga_pkg::amp_t  ram_wdata;
  logic [31:0]     ram_rdata;
  svga_pkg::amp_t  ram_rd_amp;

  // Gate address generation: the pair counter is split around the target bit.
  logic [AW-1:0]   pair_idx, low_mask, tgt_bit, z_addr, o_addr;

  // Read pipeline for a gate request.
  logic            s0_v_r;
  logic            s0_ph_r;
  logic [AW-1:0]   s0_addr_r;
  svga_pkg::amp_t  z_hold_r;
  logic [AW-1:0]   z_hold_addr_r;
  svga_pkg::amp_t  pair_z_r, pair_o_r;
  logic [AW-1:0]   pz_addr_r, po_addr_r;
  logic            upd_z_r, upd_o_r;
  logic            pair_v_r, pair_v_d_r;

  // Multiply stage interface.
  logic            cmac_en, cmac_sel;
  logic [AW-1:0]   cmac_addr;
  logic            cmac_we;
  logic [AW-1:0]   cmac_waddr;
  svga_pkg::amp_t  cmac_wdata;

  // Read result path.
  logic            prob_load;
  svga_pkg::amp_t  prob_amp;
  logic [15:0]     prob_val;
  logic            out_load;
  logic            out_valid_r;
  logic [47:0]     out_data_r;

  // An entry may be rewritten only when every control bit is set in its own index.
  // Control bits above the store never match, since the index has zeros there.
  function automatic logic ctrl_ok(input logic [AW-1:0] idx, input logic [9:0] mask);
    logic [MW-1:0] i_ext;
    logic [MW-1:0] m_ext;
    i_ext   = MW'(idx);
    m_ext   = MW'(mask);
    ctrl_ok = ((i_ext & m_ext) == m_ext);
  endfunction

  assign pair_idx = rd_cnt_r >> 1;
  assign tgt_bit  = AW'(1) << item_tgt_r;
  assign low_mask = tgt_bit - AW'(1);
  assign z_addr   = (pair_idx & low_mask) | ((pair_idx & ~low_mask) << 1);
  assign o_addr   = z_addr | tgt_bit;

  assign ram_rd_amp = svga_pkg::amp_t'(ram_rdata);

  // The store keeps one request at a time, so the input side opens only when idle.
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    rd_cnt_nxt  = rd_cnt_r;
    ram_we      = cmac_we;
    ram_waddr   = cmac_waddr;
    ram_wdata   = cmac_wdata;
    ram_re      = 1'b0;
    ram_raddr   = item_addr_r;
    prob_load   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = (clr_cnt_r == '0) ? svga_pkg::AMP_ONE : '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_tuser)
            svga_pkg::OP_WRITE: state_nxt = S_WR;
            svga_pkg::OP_READ:  state_nxt = S_RD;
            svga_pkg::OP_GATE: begin
              // A target beyond the store leaves every entry as it is.
              if (32'(in_target_index) < QUBITS) begin
                state_nxt  = S_GATE;
                rd_cnt_nxt = '0;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = item_addr_r;
        ram_wdata = item_amp_r;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        prob_load = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_GATE: begin
        // Even counts read the zero-side entry of a pair, odd counts the one-side entry.
        ram_re     = 1'b1;
        ram_raddr  = rd_cnt_r[0] ? o_addr : z_addr;
        rd_cnt_nxt = rd_cnt_r + AW'(1);
        if (&rd_cnt_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s0_v_r && !pair_v_r && !pair_v_d_r && !cmac_we) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      rd_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_addr_r   <= in_addr_ext[AW-1:0];
      item_amp_r.re <= in_write_re;
      item_amp_r.im <= in_write_im;
      item_tgt_r    <= in_target_index;
      item_mask_r   <= in_control_mask;
    end
  end

  // Gate read pipeline. Each entry is read once and written at most once per gate, and the
  // pairs are disjoint, so a later read never meets an entry still waiting to be written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      pair_v_r   <= 1'b0;
      pair_v_d_r <= 1'b0;
    end else begin
      s0_v_r     <= (state_r == S_GATE);
      pair_v_r   <= s0_v_r && s0_ph_r;
      pair_v_d_r <= pair_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_ph_r   <= rd_cnt_r[0];
    s0_addr_r <= ram_raddr;
    if (s0_v_r) begin
      if (!s0_ph_r) begin
        z_hold_r      <= ram_rd_amp;
        z_hold_addr_r <= s0_addr_r;
      end else begin
        pair_z_r  <= z_hold_r;
        pair_o_r  <= ram_rd_amp;
        pz_addr_r <= z_hold_addr_r;
        po_addr_r <= s0_addr_r;
        upd_z_r   <= ctrl_ok(z_hold_addr_r, item_mask_r);
        upd_o_r   <= ctrl_ok(s0_addr_r, item_mask_r);
      end
    end
  end

  // A held pair is used twice: first for the zero-side row, then for the one-side row.
  assign cmac_sel  = pair_v_d_r;
  assign cmac_addr = cmac_sel ? po_addr_r : pz_addr_r;
  assign cmac_en   = cmac_sel ? upd_o_r : (pair_v_r && upd_z_r);

  svga_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  svga_cmac #(
    .AW (AW)
  ) u_cmac (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_en   (cmac_en),
    .in_sel  (cmac_sel),
    .in_addr (cmac_addr),
    .in_z    (pair_z_r),
    .in_o    (pair_o_r),
    .coef    (coef),
    .wr_en   (cmac_we),
    .wr_addr (cmac_waddr),
    .wr_data (cmac_wdata)
  );

  svga_prob u_prob (
    .clk         (clk),
    .load        (prob_load),
    .amp         (ram_rd_amp),
    .amp_out     (prob_amp),
    .probability (prob_val)
  );

  // Output register: holds a read result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {prob_val, prob_amp.im, prob_amp.re};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A fresh result only ever comes from the last step of a read.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RD2)
    else $error("read result appeared outside a read request");

  // A new request is taken only once the gate pipeline has fully drained.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!s0_v_r && !pair_v_r && !pair_v_d_r && !cmac_we))
    else $error("request accepted while gate writes still pending");

  // The store is written only by the clearing sweep, a write request or a gate.
  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_WR || state_r == S_GATE ||
                state_r == S_DRAIN))
    else $error("store written in an unexpected state");

  // Pairs never arrive back to back, as the multiply stage reuses each twice.
  a_pair_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    pair_v_r |=> !pair_v_r)
    else $error("amplitude pairs arrived back to back");

endmodule

// File: bench/gate_apply_tb_pkg.sv
package gate_apply_tb_pkg;
  import svga_pkg::*;

  localparam int QUBITS = 10;
  localparam int STORE_DEPTH = 1 << QUBITS;

  // The fourth operation code has no meaning and must leave the block untouched.
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct {
    op_t                op;
    logic [9:0]         address;
    logic signed [15:0] wre;
    logic signed [15:0] wim;
    logic [3:0]         target;
    logic [9:0]         mask;
  } request_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [15:0]        prob;
  } read_result_t;

  // Mirrors the amplitude store and the gate registers, and keeps the read results
  // still owed by the block in request order.
  class amplitude_predictor;
    logic signed [15:0] amp_re [STORE_DEPTH];
    logic signed [15:0] amp_im [STORE_DEPTH];
    logic signed [15:0] coef [CFG_REGS];
    read_result_t       owed_reads [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < STORE_DEPTH; i++) begin
        amp_re[i] = '0;
        amp_im[i] = '0;
      end
      amp_re[0] = AMP_ONE.re;
      amp_im[0] = AMP_ONE.im;
      for (int i = 0; i < CFG_REGS; i++) coef[i] = CFG_RESET[i];
      mismatches = 0;
    endfunction

    function void set_coef(int idx, logic [15:0] value);
      coef[idx] = value;
    endfunction

    function int pending();
      return owed_reads.size();
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: %s expected %0d got %0d", what, want, got);
    endfunction

    // Q2.30 sum to Q1.15: add half an LSB, floor shift, saturate.
    function logic signed [15:0] round_q15(longint sum);
      longint q;
      q = (sum + 64'sd16384) >>> 15;
      if (q > 32767) return 16'sh7FFF;
      if (q < -32768) return 16'sh8000;
      return q[15:0];
    endfunction

    // m*x + n*y, where m and n are complex coefficients held as re/im register pairs.
    function void combine(int m, int n, longint xr, longint xi, longint yr, longint yi,
                          output logic signed [15:0] res_re, output logic signed [15:0] res_im);
      longint mr, mi, nr, ni;
      mr = coef[m];
      mi = coef[m + 1];
      nr = coef[n];
      ni = coef[n + 1];
      res_re = round_q15(mr * xr - mi * xi + nr * yr - ni * yi);
      res_im = round_q15(mr * xi + mi * xr + nr * yi + ni * yr);
    endfunction

    function void take_request(request_t r);
      read_result_t exp;
      longint       re, im, mag;
      int unsigned  low, z, o, cmask;
      longint       zr, zi, orr, oi;
      case (r.op)
        OP_WRITE: begin
          amp_re[r.address] = r.wre;
          amp_im[r.address] = r.wim;
        end
        OP_READ: begin
          re = amp_re[r.address];
          im = amp_im[r.address];
          mag = re * re + im * im;
          mag = (mag + 16384) >> 15;
          exp.re = amp_re[r.address];
          exp.im = amp_im[r.address];
          exp.prob = (mag > 65535) ? 16'hFFFF : mag[15:0];
          owed_reads.insert(owed_reads.size(), exp);
        end
        OP_GATE: begin
          if (r.target < QUBITS) begin
            low = (1 << r.target) - 1;
            cmask = r.mask;
            for (int i = 0; i < STORE_DEPTH / 2; i++) begin
              z = (i & low) | ((i & ~low) << 1);
              o = z | (1 << r.target);
              zr = amp_re[z];
              zi = amp_im[z];
              orr = amp_re[o];
              oi = amp_im[o];
              if ((z & cmask) == cmask)
                combine(CFG_A_RE, CFG_B_RE, zr, zi, orr, oi, amp_re[z], amp_im[z]);
              if ((o & cmask) == cmask)
                combine(CFG_C_RE, CFG_D_RE, zr, zi, orr, oi, amp_re[o], amp_im[o]);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [47:0] data);
      read_result_t       exp;
      logic signed [15:0] got_re, got_im;
      logic [15:0]        got_p;
      got_re = data[15:0];
      got_im = data[31:16];
      got_p = data[47:32];
      if (owed_reads.size() == 0) begin
        flag("read result with no read request waiting, real part", 0, got_re);
        return;
      end
      exp = owed_reads.pop_front();
      if (got_re !== exp.re) flag("read real part", exp.re, got_re);
      if (got_im !== exp.im) flag("read imaginary part", exp.im, got_im);
      if (got_p !== exp.prob) flag("probability", exp.prob, got_p);
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svga_pkg::*;
  import gate_apply_tb_pkg::*;

  // A gate request walks the whole store and then drains the multiply pipeline, so this
  // is how long the block may still be busy after the last read result has come out.
  localparam int GATE_DRAIN = STORE_DEPTH + 64;
  // Length of the deliberate receiver hold-off that backs up the block.
  localparam int HOLD_CYCLES = 2000;
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES = 6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  op_t         in_tuser;   // operation
  logic [55:0] in_tdata;   // address, write_re, write_im, target_index, control_mask
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // read_re, read_im, probability
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit long_hold = 1'b0;

  amplitude_predictor model = new();

  state_vector_gate_apply #(.QUBITS(QUBITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic request_t make_req(op_t op, int addr, int wre, int wim, int tgt,
                                        int mask);
    request_t r;
    r.op = op;
    r.address = 10'(addr);
    r.wre = 16'(wre);
    r.wim = 16'(wim);
    r.target = 4'(tgt);
    r.mask = 10'(mask);
    return r;
  endfunction

  // Offers one request and holds it until the block takes it. The predictor is told at
  // the edge of acceptance, so it always sees the gate registers that the block uses.
  // Valid is only lowered when an idle gap follows, so back-to-back requests keep it high.
  task automatic push_request(input request_t r, input int gap);
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tdata <= {r.mask, r.target, r.wim, r.wre, r.address};
    do @(posedge clk); while (!in_tready);
    model.take_request(r);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering requests, waits for every owed read result, then lets a possible
  // gate request run to completion so that the block is truly idle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (model.pending() > 0) @(posedge clk);
    repeat (GATE_DRAIN) @(posedge clk);
  endtask

  // One register write (setup then access), followed by a read-back of the same register.
  // The port is left idle before the next transfer.
  task automatic cfg_write(input int idx, input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx * 4);
    cfg_pwdata <= {16'h0000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model.set_coef(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== value) model.flag("register read-back", value, cfg_prdata[15:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // The packed gate holds a_re in its top bits, so register i sits at slice 7-i.
  task automatic load_gate(input gate_t g);
    for (int i = 0; i < CFG_REGS; i++) cfg_write(i, g[(CFG_REGS - 1 - i) * 16 +: 16]);
  endtask

  // Result side. Handshakes are taken at the rising edge from the values that were
  // settled before it; ready for the next cycle is then chosen. Stalls are random in
  // length, with occasional stretches of constant readiness, and one long hold-off
  // counted here on request of the stimulus.
  initial begin
    int stall_left;
    int steady_left;
    int r;
    stall_left = 0;
    steady_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        model.check_read(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (long_hold) begin
        long_hold = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          steady_left = $urandom_range(50, 300);
          out_tready <= 1'b1;
        end else if (r < 70) begin
          out_tready <= 1'b1;
        end else begin
          stall_left = pick_gap();
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    request_t req;
    gate_t    g;
    int       sent;
    int       burst_left;
    int       r;
    int       gap;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= OP_WRITE;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the gate registers still at their reset values. The block
    // clears its store after reset; the first request simply waits for that to finish.
    push_request(make_req(OP_READ, 0, 0, 0, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 1023, 0, 0, 0, 0), pick_gap());
    // Most negative amplitude on both parts: the probability has to saturate.
    push_request(make_req(OP_WRITE, 1023, -32768, -32768, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 1023, 0, 0, 0, 0), pick_gap());
    push_request(make_req(OP_WRITE, 5, 32767, -32768, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 5, 0, 0, 0, 0), pick_gap());
    // The unused operation with every field bit set must change nothing.
    push_request(make_req(OP_UNUSED, 1023, -1, -1, 15, 1023), pick_gap());
    push_request(make_req(OP_READ, 5, 0, 0, 0, 0), pick_gap());
    // A plain gate on the lowest qubit.
    push_request(make_req(OP_GATE, 0, 0, 0, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 0, 0, 0, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 1, 0, 0, 0, 0), pick_gap());
    // Targets past the top qubit leave the store alone.
    push_request(make_req(OP_GATE, 0, 0, 0, 10, 0), pick_gap());
    push_request(make_req(OP_GATE, 0, 0, 0, 15, 0), pick_gap());
    // Every control bit set: only the last entry qualifies, and it includes the target.
    push_request(make_req(OP_GATE, 0, 0, 0, 9, 1023), pick_gap());
    push_request(make_req(OP_READ, 1023, 0, 0, 0, 0), pick_gap());
    // A control bit on the target itself: only the partner with that bit set is updated.
    push_request(make_req(OP_WRITE, 0, 16384, -16384, 0, 0), pick_gap());
    push_request(make_req(OP_WRITE, 4, -16384, 8192, 0, 0), pick_gap());
    push_request(make_req(OP_GATE, 0, 0, 0, 2, 10'h004), pick_gap());
    push_request(make_req(OP_READ, 0, 0, 0, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 4, 0, 0, 0, 0), pick_gap());
    push_request(make_req(OP_READ, 512, 0, 0, 0, 0), 0);
    wait_drained();

    // Random phases, each under its own gate. The first two use the register extremes,
    // which drive the gate arithmetic into saturation.
    burst_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: g = {8{16'h8000}};
        1: g = {8{16'h7FFF}};
        2: begin
          g = '0;
          g.b_re = 16'sh7FFF;
          g.c_re = 16'sh7FFF;
        end
        3: begin
          g = '0;
          g.a_re = 16'sd23170;
          g.b_re = 16'sd23170;
          g.c_re = 16'sd23170;
          g.d_re = -16'sd23170;
        end
        default: g = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_gate(g);

      sent = 0;
      if (phase == 2) begin
        // The receiver holds off for a long while; back-to-back reads fill the result
        // path until the block has to refuse further requests.
        long_hold = 1'b1;
        for (int k = 0; k < 30; k++) begin
          push_request(make_req(OP_READ, $urandom_range(0, 1023), $urandom, $urandom,
                                $urandom_range(0, 15), $urandom_range(0, 1023)), 0);
          sent++;
        end
      end

      while (sent < PHASE_ITEMS) begin
        // Addresses lean towards a small corner of the store so that reads mostly find
        // entries that earlier writes and gates have touched.
        req.address = $urandom_range(0, 1) ? 10'($urandom_range(0, 15))
                                           : 10'($urandom_range(0, 1023));
        req.wre = 16'($urandom);
        req.wim = 16'($urandom);
        req.target = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, QUBITS - 1));
        r = $urandom_range(0, 9);
        if (r < 6) req.mask = '0;
        else if (r < 9) req.mask = (10'd1 << $urandom_range(0, 9)) |
                                   (10'd1 << $urandom_range(0, 9));
        else req.mask = 10'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) req.op = OP_WRITE;
        else if (r < 83) req.op = OP_READ;
        else if (r < 97) req.op = OP_GATE;
        else req.op = OP_UNUSED;

        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else if ($urandom_range(0, 99) < 8) begin
          burst_left = $urandom_range(20, 60);
          gap = 0;
        end else begin
          gap = pick_gap();
        end
        push_request(req, gap);

        if (req.op != OP_UNUSED) begin
          sent++;
          // Once in the run the sender stops until the block has caught up completely.
          if (phase == 1 && sent == PHASE_ITEMS / 2) wait_drained();
        end
      end
      wait_drained();
    end

    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
